FILE: src/lzwd_pkg.sv
// Shared constants, types and control structs for the LZW code decoder.
package lzwd_pkg;

  localparam int CODE_BITS  = 12;
  localparam int DICT_DEPTH = 1 << CODE_BITS;
  localparam int NF_BITS    = CODE_BITS + 1;
  localparam int MAX_PHRASE = 64;
  localparam int LEN_BITS   = 7;
  localparam int SP_BITS    = $clog2(MAX_PHRASE);
  localparam int BYTE_BITS  = 8;
  localparam int LIT_CODES  = 1 << BYTE_BITS;
  localparam int IN_TDATA_W = ((CODE_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [CODE_BITS-1:0] parent;
    logic [BYTE_BITS-1:0] suffix;
    logic [LEN_BITS-1:0]  len;
  } dict_entry_t;

  localparam int ENTRY_BITS = $bits(dict_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_LEN_CHK,
    ST_WALK,
    ST_FIRST,
    ST_APPEND,
    ST_PRIME,
    ST_EMIT,
    ST_ERR
  } state_e;

  typedef enum logic [1:0] {
    NODE_HOLD,
    NODE_CODE,
    NODE_PREV,
    NODE_PARENT
  } node_sel_e;

  typedef enum logic [1:0] {
    LEN_HOLD,
    LEN_ONE,
    LEN_PREV,
    LEN_ENTRY
  } len_sel_e;

  typedef struct packed {
    logic      capture;
    node_sel_e node_sel;
    len_sel_e  len_sel;
    logic      walk_step;
    logic      finish;
    logic      append;
    logic      emit_start;
    logic      emit_step;
    logic      err_out;
  } ctrl_t;

  typedef struct packed {
    logic in_dict;
    logic code_lit;
    logic kwk_ok;
    logic prev_len_one;
    logic entry_bad;
    logic entry_one;
    logic pos_two;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

FILE: src/lzwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lzwd_ctrl.sv
// Controller state machine for the LZW code decoder.
module lzwd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lzwd_pkg::stat_t stat_i,
  output lzwd_pkg::ctrl_t ctrl_o
);
  import lzwd_pkg::*;

  state_e state_q, state_d;
  logic   kwk_q, kwk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kwk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      kwk_q   <= kwk_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kwk_d      = kwk_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    ctrl_o.node_sel = NODE_HOLD;
    ctrl_o.len_sel  = LEN_HOLD;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        kwk_d = 1'b0;
        if (stat_i.in_dict) begin
          ctrl_o.node_sel = NODE_CODE;
          if (stat_i.code_lit) begin
            ctrl_o.len_sel = LEN_ONE;
            state_d        = ST_FIRST;
          end else begin
            state_d = ST_LEN_CHK;
          end
        end else if (stat_i.kwk_ok) begin
          ctrl_o.node_sel = NODE_PREV;
          ctrl_o.len_sel  = LEN_PREV;
          kwk_d           = 1'b1;
          state_d         = stat_i.prev_len_one ? ST_FIRST : ST_WALK;
        end else begin
          state_d = ST_ERR;
        end
      end
      ST_LEN_CHK: begin
        if (stat_i.entry_bad) begin
          state_d = ST_ERR;
        end else begin
          ctrl_o.len_sel = LEN_ENTRY;
          state_d        = stat_i.entry_one ? ST_FIRST : ST_WALK;
        end
      end
      ST_WALK: begin
        ctrl_o.walk_step = 1'b1;
        ctrl_o.node_sel  = NODE_PARENT;
        if (stat_i.pos_two) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        ctrl_o.finish = 1'b1;
        state_d       = kwk_q ? ST_APPEND : ST_PRIME;
      end
      ST_APPEND: begin
        ctrl_o.append = 1'b1;
        state_d       = ST_PRIME;
      end
      ST_PRIME: begin
        ctrl_o.emit_start = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_step = 1'b1;
          if (stat_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (stat_i.out_free) begin
          ctrl_o.err_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/lzwd_datapath.sv
// Datapath: dictionary, phrase stack, walk registers and output register.
module lzwd_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lzwd_pkg::ctrl_t                    ctrl_i,
  output lzwd_pkg::stat_t                    stat_o,
  input  logic [lzwd_pkg::CODE_BITS-1:0]     code_i,
  input  logic                               new_stream_i,
  output logic [lzwd_pkg::BYTE_BITS-1:0]     data_byte_o,
  output logic                               last_o,
  output logic                               error_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i
);
  import lzwd_pkg::*;

  logic [CODE_BITS-1:0] code_q;
  logic [NF_BITS-1:0]   nf_q, nf_d;
  logic [CODE_BITS-1:0] prev_q, prev_d;
  logic                 hp_q, hp_d;
  logic [LEN_BITS-1:0]  prev_len_q, prev_len_d;
  logic [CODE_BITS-1:0] node_q, node_d;
  logic [LEN_BITS-1:0]  pos_q, pos_d;
  logic [LEN_BITS-1:0]  len_q, len_d;
  logic [LEN_BITS-1:0]  k_q, k_d;
  logic [BYTE_BITS-1:0] first_q;
  logic                 out_valid_q, out_valid_d;
  logic [BYTE_BITS-1:0] out_byte_q;
  logic                 out_last_q, out_err_q;

  dict_entry_t          rd_entry, wr_entry;
  logic                 dict_we;
  logic                 stk_we;
  logic [SP_BITS-1:0]   stk_waddr, stk_raddr;
  logic [BYTE_BITS-1:0] stk_wdata, stk_rdata;
  logic [LEN_BITS-1:0]  pos_m1, len_m1, k_p1;
  logic                 out_free, kwk;

  assign pos_m1   = pos_q - LEN_BITS'(1);
  assign len_m1   = len_q - LEN_BITS'(1);
  assign k_p1     = k_q + LEN_BITS'(1);
  assign out_free = !out_valid_q || out_ready_i;
  assign kwk      = ({1'b0, code_q} == nf_q) && hp_q && !nf_q[CODE_BITS];

  always_comb begin
    stat_o.in_dict      = {1'b0, code_q} < nf_q;
    stat_o.code_lit     = code_q[CODE_BITS-1:BYTE_BITS] == '0;
    stat_o.kwk_ok       = kwk && (prev_len_q < LEN_BITS'(MAX_PHRASE));
    stat_o.prev_len_one = prev_len_q == LEN_BITS'(1);
    stat_o.entry_bad    = (rd_entry.len == '0) || (rd_entry.len > LEN_BITS'(MAX_PHRASE));
    stat_o.entry_one    = rd_entry.len == LEN_BITS'(1);
    stat_o.pos_two      = pos_q == LEN_BITS'(2);
    stat_o.out_free     = out_free;
    stat_o.emit_last    = k_q == len_m1;
  end

  always_comb begin
    case (ctrl_i.node_sel)
      NODE_CODE:   node_d = code_q;
      NODE_PREV:   node_d = prev_q;
      NODE_PARENT: node_d = rd_entry.parent;
      default:     node_d = node_q;
    endcase
    len_d = len_q;
    pos_d = pos_q;
    case (ctrl_i.len_sel)
      LEN_ONE: begin
        len_d = LEN_BITS'(1);
        pos_d = LEN_BITS'(1);
      end
      LEN_PREV: begin
        len_d = prev_len_q + LEN_BITS'(1);
        pos_d = prev_len_q;
      end
      LEN_ENTRY: begin
        len_d = rd_entry.len;
        pos_d = rd_entry.len;
      end
      default: begin
      end
    endcase
    if (ctrl_i.walk_step) begin
      pos_d = pos_m1;
    end
  end

  always_comb begin
    nf_d       = nf_q;
    hp_d       = hp_q;
    prev_d     = prev_q;
    prev_len_d = prev_len_q;
    dict_we    = 1'b0;
    if (ctrl_i.capture && new_stream_i) begin
      nf_d = NF_BITS'(LIT_CODES);
      hp_d = 1'b0;
    end
    if (ctrl_i.finish) begin
      if (hp_q && !nf_q[CODE_BITS]) begin
        dict_we = 1'b1;
        nf_d    = nf_q + NF_BITS'(1);
      end
      prev_d     = code_q;
      hp_d       = 1'b1;
      prev_len_d = len_q;
    end
  end

  always_comb begin
    wr_entry.parent = prev_q;
    wr_entry.suffix = node_q[BYTE_BITS-1:0];
    wr_entry.len    = prev_len_q + LEN_BITS'(1);
  end

  always_comb begin
    stk_we    = ctrl_i.walk_step || ctrl_i.finish || ctrl_i.append;
    stk_waddr = pos_m1[SP_BITS-1:0];
    stk_wdata = rd_entry.suffix;
    if (ctrl_i.finish) begin
      stk_waddr = '0;
      stk_wdata = node_q[BYTE_BITS-1:0];
    end else if (ctrl_i.append) begin
      stk_waddr = len_m1[SP_BITS-1:0];
      stk_wdata = first_q;
    end
    k_d       = k_q;
    stk_raddr = k_q[SP_BITS-1:0];
    if (ctrl_i.emit_start) begin
      k_d       = '0;
      stk_raddr = '0;
    end else if (ctrl_i.emit_step) begin
      k_d       = k_p1;
      stk_raddr = k_p1[SP_BITS-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_i.emit_step || ctrl_i.err_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q        <= NF_BITS'(LIT_CODES);
      hp_q        <= 1'b0;
      prev_q      <= '0;
      prev_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      nf_q        <= nf_d;
      hp_q        <= hp_d;
      prev_q      <= prev_d;
      prev_len_q  <= prev_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      code_q <= code_i;
    end
    node_q <= node_d;
    pos_q  <= pos_d;
    len_q  <= len_d;
    k_q    <= k_d;
    if (ctrl_i.finish) begin
      first_q <= node_q[BYTE_BITS-1:0];
    end
    if (ctrl_i.emit_step) begin
      out_byte_q <= stk_rdata;
      out_last_q <= k_q == len_m1;
      out_err_q  <= 1'b0;
    end else if (ctrl_i.err_out) begin
      out_byte_q <= '0;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b1;
    end
  end

  // read data always mirrors the entry at node_q
  lzwd_ram #(
    .Width (ENTRY_BITS),
    .Depth (DICT_DEPTH)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (nf_q[CODE_BITS-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (node_d),
    .rdata_o (rd_entry)
  );

  lzwd_ram #(
    .Width (BYTE_BITS),
    .Depth (MAX_PHRASE)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign data_byte_o = out_byte_q;
  assign last_o      = out_last_q;
  assign error_o     = out_err_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/lzw_code_decoder_core.sv
// Top level of the LZW code decoder: controller plus datapath.
//
// Input channel (s_axis): one LZW code per item in tdata[11:0]; tuser set
// clears the dictionary and starts a new stream with this code.
// Output channel (m_axis): one decoded byte per item in tdata[7:0], tlast on
// the final byte of a code's phrase, tuser flags an error item (byte 0,
// tlast set) for a code past the next free slot, at it with no previous code, or a phrase over 64 bytes.
// One code is handled at a time. After acceptance the code is classified and
// looked up, the parent chain is walked through the dictionary RAM, the phrase
// stack is primed and then read out one byte a cycle while the output register
// is free. The next code is taken in the cycle after the last byte has entered
// the output register.
// After reset the dictionary holds only the 256 literal codes and the first
// code is treated as the first of a stream; dictionary RAM is not cleared.
// When the receiver stalls, the output register holds its item and the
// readout pauses; no item is lost.
module lzw_code_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] code, [15:12] zero
  input  logic        s_axis_tuser,   // new_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser    // error
);
  import lzwd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  lzwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  lzwd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .code_i       (s_axis_tdata[CODE_BITS-1:0]),
    .new_stream_i (s_axis_tuser),
    .data_byte_o  (m_axis_tdata),
    .last_o       (m_axis_tlast),
    .error_o      (m_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready)
  );

endmodule

FILE: tb/sv/lzw_code_decoder_checker.sv
// Checker for the LZW code decoder: predicts the phrase of each code and compares output items.
module lzw_code_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] code, [15:12] zero
  input  logic        s_axis_tuser,   // new_stream
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] data_byte
  input  logic        m_axis_tlast,   // last
  input  logic        m_axis_tuser,   // error
  output int unsigned fail_count_o,
  output int unsigned expected_left_o
);
  import lzwd_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       error;
  } phrase_byte_t;

  phrase_byte_t         phrase_q[$];
  logic [CODE_BITS-1:0] parent_mem [DICT_DEPTH];
  logic [7:0]           suffix_mem [DICT_DEPTH];
  logic [LEN_BITS-1:0]  len_mem    [DICT_DEPTH];
  logic [NF_BITS-1:0]   free_slot;
  logic [CODE_BITS-1:0] prev_code;
  logic                 prev_valid;
  int unsigned          mismatches;
  int unsigned          out_count;

  function automatic int unsigned phrase_len(input logic [CODE_BITS-1:0] c);
    return (c < LIT_CODES) ? 1 : int'(len_mem[c]);
  endfunction

  function automatic void decode_code(input logic nstream, input logic [CODE_BITS-1:0] c);
    logic [7:0]           phrase [MAX_PHRASE+1];
    logic [CODE_BITS-1:0] node;
    int unsigned          plen;
    int unsigned          prev_len;
    int unsigned          walk_len;
    int unsigned          pos;
    phrase_byte_t         item;
    if (nstream) begin
      free_slot  = NF_BITS'(LIT_CODES);
      prev_valid = 1'b0;
    end
    prev_len = prev_valid ? phrase_len(prev_code) : 0;
    plen     = 0;
    walk_len = 0;
    node     = c;
    if (c < free_slot) begin
      plen     = phrase_len(c);
      walk_len = plen;
    end else if (c == free_slot && prev_valid && free_slot < DICT_DEPTH) begin
      // KwKwK: previous phrase plus its own first byte
      plen     = prev_len + 1;
      walk_len = prev_len;
      node     = prev_code;
    end
    if (plen == 0 || plen > MAX_PHRASE) begin
      item     = {8'h00, 1'b1, 1'b1};
      phrase_q = {phrase_q, item};
      return;
    end
    pos = walk_len;
    while (pos > 1) begin
      pos--;
      phrase[pos] = suffix_mem[node];
      node        = parent_mem[node];
    end
    phrase[0] = node[7:0];
    if (walk_len < plen) phrase[walk_len] = phrase[0];
    if (prev_valid && free_slot < DICT_DEPTH) begin
      parent_mem[free_slot[CODE_BITS-1:0]] = prev_code;
      suffix_mem[free_slot[CODE_BITS-1:0]] = phrase[0];
      len_mem[free_slot[CODE_BITS-1:0]]    = (prev_len + 1 > 127) ? 7'd127 :
                                             LEN_BITS'(prev_len + 1);
      free_slot++;
    end
    prev_code  = c;
    prev_valid = 1'b1;
    for (pos = 0; pos < plen; pos++) begin
      item     = {phrase[pos], (pos + 1 == plen), 1'b0};
      phrase_q = {phrase_q, item};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    phrase_byte_t got;
    phrase_byte_t want;
    if (!rst_ni) begin
      phrase_q.delete();
      free_slot  = NF_BITS'(LIT_CODES);
      prev_code  = '0;
      prev_valid = 1'b0;
      mismatches = 0;
      out_count  = 0;
    end else begin
      // outputs first: they belong to codes taken before this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
        if (phrase_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("out item %0d unexpected: byte %02h last %b error %b",
                     out_count, got.data_byte, got.last, got.error);
        end else begin
          want = phrase_q.pop_front();
          if (got.data_byte !== want.data_byte || got.last !== want.last ||
              got.error !== want.error) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"out item %0d: exp byte %02h last %b error %b, ",
                        "got byte %02h last %b error %b"},
                       out_count, want.data_byte, want.last, want.error,
                       got.data_byte, got.last, got.error);
          end
        end
        out_count++;
      end
      if (s_axis_tvalid && s_axis_tready)
        decode_code(s_axis_tuser, s_axis_tdata[CODE_BITS-1:0]);
    end
    fail_count_o    <= mismatches;
    expected_left_o <= phrase_q.size();
  end

endmodule

FILE: tb/sv/tb_lzw_code_decoder_core.sv
// Testbench top for the LZW code decoder: code stimulus, handshake idling and verdict.
module tb_lzw_code_decoder_core;
  import lzwd_pkg::*;

  localparam int RANDOM_ITEMS = 380;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_ITEM = 60;
  localparam int FULL_TAIL    = 60;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_DIRECTED   = 15;

  // {new_stream, code}
  localparam logic [CODE_BITS:0] DIRECTED [N_DIRECTED] = '{
    {1'b0, 12'h041}, {1'b0, 12'h000}, {1'b0, 12'h0ff}, {1'b0, 12'h102},
    {1'b0, 12'h100}, {1'b0, 12'h12c}, {1'b0, 12'hfff}, {1'b1, 12'h103},
    {1'b0, 12'h100}, {1'b1, 12'h042}, {1'b0, 12'h100}, {1'b0, 12'h101},
    {1'b0, 12'h102}, {1'b0, 12'h800}, {1'b1, 12'h080}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  int unsigned           fail_count;
  int unsigned           expected_left;

  bit                    idle_on = 1'b1;
  int unsigned           sent_count;
  int unsigned           quiet_cycles;
  int unsigned           hold_left;
  int unsigned           rx_gap;
  bit                    hold_done;

  // dictionary growth as seen by the sender, used to aim codes
  int unsigned           gen_free;
  int unsigned           gen_prev_len;
  bit                    gen_have_prev;
  logic [LEN_BITS-1:0]   gen_len [DICT_DEPTH];

  lzw_code_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  lzw_code_decoder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .m_axis_tuser    (m_axis_tuser),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void track_code(input logic nstream, input logic [CODE_BITS-1:0] c);
    int unsigned plen;
    if (nstream) begin
      gen_free      = LIT_CODES;
      gen_have_prev = 1'b0;
    end
    if (c < gen_free)
      plen = (c < LIT_CODES) ? 1 : int'(gen_len[c]);
    else if (c == gen_free && gen_have_prev && gen_free < DICT_DEPTH)
      plen = gen_prev_len + 1;
    else
      return;
    if (plen > MAX_PHRASE) return;
    if (gen_have_prev && gen_free < DICT_DEPTH) begin
      gen_len[gen_free] = LEN_BITS'(gen_prev_len + 1);
      gen_free++;
    end
    gen_prev_len  = plen;
    gen_have_prev = 1'b1;
  endfunction

  function automatic logic [CODE_BITS-1:0] pick_code(input bit grow);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 99);
    if (roll < (grow ? 75 : 25) && gen_free < DICT_DEPTH)
      return CODE_BITS'(gen_free);
    if (roll < (grow ? 95 : 50) && gen_free > LIT_CODES) begin
      span = (gen_free - LIT_CODES > 8) ? 8 : gen_free - LIT_CODES;
      return CODE_BITS'(gen_free - 1 - $urandom_range(0, span - 1));
    end
    if (roll < 80) return CODE_BITS'($urandom_range(0, 255));
    if (roll < 93) return CODE_BITS'($urandom_range(0, gen_free - 1));
    return CODE_BITS'($urandom_range(0, DICT_DEPTH - 1));
  endfunction

  task automatic send_item(input logic nstream, input logic [CODE_BITS-1:0] code);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(code);
    s_axis_tuser  <= nstream;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_code(nstream, code);
    sent_count++;
  endtask

  // receiver: short random stalls plus one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      rx_gap    = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && sent_count >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("lzw_code_decoder_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned rand_goal;
    int unsigned run_len;
    int unsigned n;
    bit          grow;
    sent_count    = 0;
    quiet_cycles  = 0;
    gen_free      = LIT_CODES;
    gen_prev_len  = 0;
    gen_have_prev = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < N_DIRECTED; n++)
      send_item(DIRECTED[n][CODE_BITS], DIRECTED[n][CODE_BITS-1:0]);

    // random streams: mostly well-formed, some grown until phrases overflow
    rand_goal = sent_count + RANDOM_ITEMS;
    while (sent_count < rand_goal) begin
      grow    = ($urandom_range(0, 2) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      run_len = grow ? $urandom_range(60, 90) : $urandom_range(4, 40);
      if ($urandom_range(0, 9) == 0)
        send_item(1'b1, CODE_BITS'($urandom_range(0, DICT_DEPTH - 1)));
      else
        send_item(1'b1, CODE_BITS'($urandom_range(0, 255)));
      for (n = 1; n < run_len; n++)
        send_item(1'b0, pick_code(grow));
    end

    idle_on = 1'b0;
    for (n = 0; n < FULL_TAIL; n++)
      send_item(1'b0, pick_code(1'b0));
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_left == 0)
      $display("lzw_code_decoder_core: match");
    else
      $display("lzw_code_decoder_core: mismatch");
    $finish;
  end

endmodule

FILE: lzw_code_decoder_core.f
src/lzwd_pkg.sv
src/lzwd_ram.sv
src/lzwd_ctrl.sv
src/lzwd_datapath.sv
src/lzw_code_decoder_core.sv
tb/sv/lzw_code_decoder_checker.sv
tb/sv/tb_lzw_code_decoder_core.sv
